### design/b64_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Base64 stream codec.
// No dependencies; the group, drain and top-level files refer to it by scoped names.
package b64_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ORPHAN  = 2'd1,
        ST_GARBAGE = 2'd2,
        ST_TRUNC   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CLS_ALPHA   = 2'd0,
        CLS_PAD     = 2'd1,
        CLS_GARBAGE = 2'd2
    } t_char_class;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        t_status    status;
    } t_result;

    typedef struct packed {
        t_result [3:0] entry;
        logic [2:0]    count;
    } t_bundle;

endpackage

### design/b64_in_if.sv
`timescale 1ns / 1ps
// Input channel of the Base64 stream codec: valid/ready with byte and end mark.
// No dependencies.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

### design/b64_out_if.sv
`timescale 1ns / 1ps
// Result channel of the Base64 stream codec: valid/ready with byte and status.
// No dependencies.
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input run_last, output ready);
endinterface

### design/b64_group.sv
`timescale 1ns / 1ps
// Group state and codec logic: gathers bytes or characters, forms result bundles.
// Depends on b64_pkg and b64_in_if.
module b64_group (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    b64_in_if.sink            i_in,
    input  logic              i_ld_ready,
    output logic              o_ld_valid,
    output b64_pkg::t_bundle  o_ld
);

    typedef struct packed {
        b64_pkg::t_char_class cls;
        logic [5:0]           val;
    } t_class_val;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      sextet_char = 8'h41 + w;
        else if (v < 6'd52) sextet_char = 8'h47 + w;
        else if (v < 6'd62) sextet_char = w - 8'd4;
        else if (v == 6'd62) sextet_char = 8'h2B;
        else                 sextet_char = 8'h2F;
    endfunction

    function automatic t_class_val classify(input logic [7:0] c);
        t_class_val r;
        logic [7:0] d;
        r.cls = b64_pkg::CLS_GARBAGE;
        r.val = 6'd0;
        d     = 8'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            d = c - 8'h41;
            r.cls = b64_pkg::CLS_ALPHA;
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - 8'h47;
            r.cls = b64_pkg::CLS_ALPHA;
        end else if (c inside {[8'h30:8'h39]}) begin
            d = c + 8'd4;
            r.cls = b64_pkg::CLS_ALPHA;
        end else if (c == 8'h2B) begin
            d = 8'd62;
            r.cls = b64_pkg::CLS_ALPHA;
        end else if (c == 8'h2F) begin
            d = 8'd63;
            r.cls = b64_pkg::CLS_ALPHA;
        end else if (c == b64_pkg::PAD_CHAR) begin
            r.cls = b64_pkg::CLS_PAD;
        end
        r.val = d[5:0];
        classify = r;
    endfunction

    function automatic b64_pkg::t_result mk_byte(input logic [7:0] b);
        b64_pkg::t_result r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.status     = b64_pkg::ST_OK;
        mk_byte = r;
    endfunction

    function automatic b64_pkg::t_result mk_status(input b64_pkg::t_status s);
        b64_pkg::t_result r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.status     = s;
        mk_status = r;
    endfunction

    function automatic b64_pkg::t_bundle quad_decode(input logic [23:0] bits,
                                                     input logic [7:0]  cls);
        b64_pkg::t_bundle b;
        logic [5:0] v0, v1, v2, v3;
        logic [1:0] c0, c1, c2, c3;
        b  = '0;
        v0 = bits[23:18];
        v1 = bits[17:12];
        v2 = bits[11:6];
        v3 = bits[5:0];
        c0 = cls[1:0];
        c1 = cls[3:2];
        c2 = cls[5:4];
        c3 = cls[7:6];
        if (c0 != b64_pkg::CLS_PAD) begin
            if (c1 == b64_pkg::CLS_PAD) begin
                b.entry[0] = mk_status(b64_pkg::ST_ORPHAN);
                b.count    = 3'd1;
            end else if (c0 != b64_pkg::CLS_ALPHA || c1 != b64_pkg::CLS_ALPHA) begin
                b.entry[0] = mk_status(b64_pkg::ST_GARBAGE);
                b.count    = 3'd1;
            end else begin
                b.entry[0] = mk_byte({v0, v1[5:4]});
                b.count    = 3'd1;
                if (c2 != b64_pkg::CLS_PAD) begin
                    if (c2 != b64_pkg::CLS_ALPHA) begin
                        b.entry[1] = mk_status(b64_pkg::ST_GARBAGE);
                        b.count    = 3'd2;
                    end else begin
                        b.entry[1] = mk_byte({v1[3:0], v2[5:2]});
                        b.count    = 3'd2;
                        if (c3 != b64_pkg::CLS_PAD) begin
                            if (c3 != b64_pkg::CLS_ALPHA) begin
                                b.entry[2] = mk_status(b64_pkg::ST_GARBAGE);
                            end else begin
                                b.entry[2] = mk_byte({v2[1:0], v3});
                            end
                            b.count = 3'd3;
                        end
                    end
                end
            end
        end
        quad_decode = b;
    endfunction

    logic             r_mode;
    logic [23:0]      r_group_bits;
    logic [7:0]       r_char_classes;
    logic [1:0]       r_group_fill;

    logic             n_mode;
    logic [23:0]      n_group_bits;
    logic [7:0]       n_char_classes;
    logic [1:0]       n_group_fill;

    logic             accept;
    logic [1:0]       enc_fill;
    logic [1:0]       enc_nfill;
    logic [23:0]      enc_bits;
    logic [23:0]      dec_bits;
    logic [7:0]       dec_classes;
    t_class_val       cv;
    b64_pkg::t_bundle bundle;

    assign accept     = i_in.valid && i_ld_ready;
    assign i_in.ready = i_ld_ready;
    assign o_ld       = bundle;
    assign o_ld_valid = accept && (bundle.count != 3'd0);

    always_comb begin
        enc_fill  = (r_group_fill == 2'd3) ? 2'd0 : r_group_fill;
        enc_nfill = enc_fill + 2'd1;
        case (enc_fill)
            2'd0:    enc_bits = r_group_bits | {i_in.in_byte, 16'h0000};
            2'd1:    enc_bits = r_group_bits | {8'h00, i_in.in_byte, 8'h00};
            default: enc_bits = r_group_bits | {16'h0000, i_in.in_byte};
        endcase

        cv = classify(i_in.in_byte);
        case (r_group_fill)
            2'd0:    dec_bits = r_group_bits | {cv.val, 18'h0};
            2'd1:    dec_bits = r_group_bits | {6'h0, cv.val, 12'h0};
            2'd2:    dec_bits = r_group_bits | {12'h0, cv.val, 6'h0};
            default: dec_bits = r_group_bits | {18'h0, cv.val};
        endcase
        dec_classes = r_char_classes | ({6'h00, cv.cls} << {r_group_fill, 1'b0});

        bundle         = '0;
        n_mode         = r_mode;
        n_group_bits   = r_group_bits;
        n_char_classes = r_char_classes;
        n_group_fill   = r_group_fill;

        if (!r_mode) begin
            if (enc_nfill == 2'd3 || i_in.end_of_data) begin
                bundle.entry[0] = mk_byte(sextet_char(enc_bits[23:18]));
                bundle.entry[1] = mk_byte(sextet_char(enc_bits[17:12]));
                bundle.entry[2] = mk_byte((enc_nfill > 2'd1) ?
                                          sextet_char(enc_bits[11:6]) : b64_pkg::PAD_CHAR);
                bundle.entry[3] = mk_byte((enc_nfill > 2'd2) ?
                                          sextet_char(enc_bits[5:0]) : b64_pkg::PAD_CHAR);
                bundle.count    = 3'd4;
                if (accept) begin
                    n_group_bits   = '0;
                    n_char_classes = '0;
                    n_group_fill   = '0;
                end
            end else if (accept) begin
                n_group_bits = enc_bits;
                n_group_fill = enc_nfill;
            end
        end else begin
            if (r_group_fill == 2'd3) begin
                bundle = quad_decode(dec_bits, dec_classes);
                if (accept) begin
                    n_group_bits   = '0;
                    n_char_classes = '0;
                    n_group_fill   = '0;
                end
            end else if (i_in.end_of_data) begin
                bundle.entry[0] = mk_status(b64_pkg::ST_TRUNC);
                bundle.count    = 3'd1;
                if (accept) begin
                    n_group_bits   = '0;
                    n_char_classes = '0;
                    n_group_fill   = '0;
                end
            end else if (accept) begin
                n_group_bits   = dec_bits;
                n_char_classes = dec_classes;
                n_group_fill   = r_group_fill + 2'd1;
            end
        end

        if (i_cfg_we) begin
            n_mode         = i_cfg_wdata;
            n_group_bits   = '0;
            n_char_classes = '0;
            n_group_fill   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_group_bits   <= '0;
            r_char_classes <= '0;
            r_group_fill   <= '0;
        end else begin
            r_mode         <= n_mode;
            r_group_bits   <= n_group_bits;
            r_char_classes <= n_char_classes;
            r_group_fill   <= n_group_fill;
        end
    end

endmodule

### design/b64_drain.sv
`timescale 1ns / 1ps
// Result bundle register and output register; sends one result per transaction.
// Depends on b64_pkg and b64_out_if.
module b64_drain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ld_valid,
    output logic              o_ld_ready,
    input  b64_pkg::t_bundle  i_ld,
    b64_out_if.source         o_out
);

    b64_pkg::t_bundle r_bndl;
    logic [1:0]       r_idx;
    logic             r_busy;
    b64_pkg::t_result r_out;
    logic             r_out_last;
    logic             r_out_valid;

    logic [1:0]       n_idx;
    logic             n_busy;
    logic             n_out_valid;

    logic             move;
    logic             fin;
    logic             load;
    logic [1:0]       cnt_m1;

    assign cnt_m1     = r_bndl.count[1:0] - 2'd1;
    assign move       = r_busy && (!r_out_valid || o_out.ready);
    assign fin        = move && (r_idx == cnt_m1);
    assign o_ld_ready = !r_busy || fin;
    assign load       = i_ld_valid && o_ld_ready;

    always_comb begin
        n_idx       = r_idx;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        if (move) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 2'd1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (fin) begin
            n_busy = 1'b0;
        end
        if (load) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bndl <= i_ld;
        end
        if (move) begin
            r_out      <= r_bndl.entry[r_idx];
            r_out_last <= (r_idx == cnt_m1);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out.out_byte;
    assign o_out.byte_valid = r_out.byte_valid;
    assign o_out.status     = r_out.status;
    assign o_out.run_last   = r_out_last;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_bndl.count != 3'd0 && r_bndl.count <= 3'd4))
        else $error("bundle held with no results");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.byte_valid |-> o_out.status == b64_pkg::ST_OK)
        else $error("data result carries a status");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy && r_idx == 2'd0)
        else $error("loaded bundle not pending");

endmodule

### design/base64_stream_codec_core.sv
`timescale 1ns / 1ps
// Top level of the Base64 stream codec: group logic feeding the result drain.
// Depends on b64_pkg, b64_in_if, b64_out_if, b64_group and b64_drain.
//
// Streaming RFC 4648 Base64 encoder/decoder; i_cfg_wdata written through
// i_cfg_we selects encode (0) or decode (1) and discards any partial group.
// The first result of an accepted item passes through the result bundle register
// and then the output register. Results leave one per cycle through the output
// register while the output is ready, so the input is taken every cycle while
// items yield at most one result and the output is ready; after an item that
// yields more than one result, as a completed encode group does, the next item
// is taken only when its last result moves out of the one-entry result bundle
// register in front of the output register.
module base64_stream_codec_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    b64_in_if.sink     i_in,
    b64_out_if.source  o_out
);

    logic             ld_valid;
    logic             ld_ready;
    b64_pkg::t_bundle ld;

    b64_group u_group (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_ld_ready  (ld_ready),
        .o_ld_valid  (ld_valid),
        .o_ld        (ld)
    );

    b64_drain u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld_valid (ld_valid),
        .o_ld_ready (ld_ready),
        .i_ld       (ld),
        .o_out      (o_out)
    );

endmodule
